@@ sv/dvru_pkg.sv @@
// Shared types and constants of the distance-vector route update unit.
package dvru_pkg;

  // Request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_ADV  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Result status codes
  localparam logic [3:0] ST_UPDATED     = 4'd0;
  localparam logic [3:0] ST_UNCHANGED   = 4'd1;
  localparam logic [3:0] ST_ADDED       = 4'd2;
  localparam logic [3:0] ST_FULL        = 4'd3;
  localparam logic [3:0] ST_NO_NEIGHBOR = 4'd4;
  localparam logic [3:0] ST_SELF        = 4'd5;
  localparam logic [3:0] ST_LOADED      = 4'd6;
  localparam logic [3:0] ST_READ_OK     = 4'd7;
  localparam logic [3:0] ST_EMPTY       = 4'd8;

  // Port to node id mapping
  localparam logic [15:0] PORT_BASE = 16'd10000;
  localparam logic [15:0] ID_BASE   = 16'd65;

  // Configuration register map
  localparam int unsigned PADDR_W   = 3;
  localparam logic        REG_OWN_ID = 1'b0;
  localparam logic [7:0]  OWN_ID_RESET = 8'd65;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] neighbor_port;
    logic [7:0]  dest_id;
    logic [15:0] adv_cost;
    logic [4:0]  read_index;
  } request_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  entry_dest;
    logic [15:0] entry_cost;
    logic [15:0] entry_port;
    logic        entry_valid;
  } result_t;

  // One route table word
  typedef struct packed {
    logic [7:0]  dest;
    logic [15:0] cost;
    logic [15:0] port;
  } route_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic idx_rd;
    logic decide;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic scan_last;
  } dp_status_t;

endpackage

@@ sv/dvru_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dvru_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/dvru_ctrl.sv @@
// Controller state machine of the route update unit.
module dvru_ctrl import dvru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_RDISSUE = 5'b00010,
    S_SCAN    = 5'b00100,
    S_DRAIN   = 5'b01000,
    S_DECIDE  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          dp_cmd.capture = 1'b1;
          case (req_type) inside
            REQ_LOAD, REQ_ADV: begin
              state_next = dp_status.count_zero ? S_DECIDE : S_SCAN;
            end
            REQ_READ: state_next = S_RDISSUE;
            default:  state_next = S_DECIDE;
          endcase
        end
      end
      S_RDISSUE: begin
        dp_cmd.idx_rd = 1'b1;
        state_next    = S_DECIDE;
      end
      S_SCAN: begin
        dp_cmd.scan_rd = 1'b1;
        if (dp_status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        dp_cmd.decide = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ sv/dvru_datapath.sv @@
// Datapath of the route update unit: request hold, table scan and relaxation.
module dvru_datapath import dvru_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  request_t   request,
  input  logic [7:0] own_id,
  input  dp_cmd_t    dp_cmd,
  output dp_status_t dp_status,
  output logic       done,
  output result_t    result
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  request_t         rq;
  logic [7:0]       nb_id;
  logic             rd_ok;
  logic [IDX_W-1:0] scan_addr;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             nb_hit;
  logic [15:0]      nb_cost;
  logic             dst_hit;
  logic [IDX_W-1:0] dst_idx;
  logic [15:0]      dst_cost;
  logic [15:0]      dst_port;
  logic [CNT_W-1:0] count;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  route_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [$bits(route_t)-1:0] ram_rdata_raw;
  route_t           ram_rdata;

  logic [16:0]      cand_sum;
  logic [15:0]      cand;
  logic             full;
  logic             count_inc;
  result_t          result_next;

  assign ram_rdata = route_t'(ram_rdata_raw);
  assign ram_re    = dp_cmd.scan_rd | dp_cmd.idx_rd;
  assign ram_raddr = dp_cmd.scan_rd ? scan_addr : IDX_W'(rq.read_index);

  dvru_ram #(
    .WIDTH ($bits(route_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign dp_status.count_zero = (count == '0);
  assign dp_status.scan_last  = ((CNT_W'(scan_addr) + CNT_W'(1)) == count);

  // Hold the request and clear the scan results on accept
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      rq    <= request;
      nb_id <= 8'(request.neighbor_port - PORT_BASE + ID_BASE);
      rd_ok <= ({{CNT_W{1'b0}}, request.read_index} < {5'd0, count});
    end
  end

  // Scan: one table read per cycle, compare on the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= dp_cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      scan_addr <= '0;
      nb_hit    <= 1'b0;
      dst_hit   <= 1'b0;
    end else begin
      if (dp_cmd.scan_rd) begin
        scan_addr <= scan_addr + IDX_W'(1);
        cmp_idx   <= scan_addr;
      end
      if (cmp_vld) begin
        if (!nb_hit && ram_rdata.dest == nb_id) begin
          nb_hit  <= 1'b1;
          nb_cost <= ram_rdata.cost;
        end
        if (!dst_hit && ram_rdata.dest == rq.dest_id) begin
          dst_hit  <= 1'b1;
          dst_idx  <= cmp_idx;
          dst_cost <= ram_rdata.cost;
          dst_port <= ram_rdata.port;
        end
      end
    end
  end

  assign cand_sum = {1'b0, rq.adv_cost} + {1'b0, nb_cost};
  assign cand     = cand_sum[16] ? 16'hFFFF : cand_sum[15:0];
  assign full     = (count == CNT_W'(TABLE_ENTRIES));

  // Relax, load or read, then form the result
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = count[IDX_W-1:0];
    ram_wdata   = '{dest: rq.dest_id, cost: rq.adv_cost, port: rq.neighbor_port};
    count_inc   = 1'b0;
    result_next = '{status: ST_EMPTY, entry_dest: 8'd0, entry_cost: 16'd0,
                    entry_port: 16'd0, entry_valid: 1'b0};
    case (rq.req_type)
      REQ_LOAD: begin
        result_next = '{status: ST_LOADED, entry_dest: rq.dest_id,
                        entry_cost: rq.adv_cost, entry_port: rq.neighbor_port,
                        entry_valid: 1'b1};
        if (dst_hit) begin
          ram_we    = 1'b1;
          ram_waddr = dst_idx;
        end else if (full) begin
          result_next.status      = ST_FULL;
          result_next.entry_valid = 1'b0;
        end else begin
          ram_we    = 1'b1;
          count_inc = 1'b1;
        end
      end
      REQ_ADV: begin
        ram_wdata.cost = cand;
        result_next = '{status: ST_ADDED, entry_dest: rq.dest_id,
                        entry_cost: cand, entry_port: rq.neighbor_port,
                        entry_valid: 1'b1};
        if (!nb_hit) begin
          result_next.status      = ST_NO_NEIGHBOR;
          result_next.entry_cost  = rq.adv_cost;
          result_next.entry_valid = 1'b0;
        end else if (dst_hit) begin
          if (cand < dst_cost) begin
            ram_we             = 1'b1;
            ram_waddr          = dst_idx;
            result_next.status = ST_UPDATED;
          end else begin
            result_next.status     = ST_UNCHANGED;
            result_next.entry_cost = dst_cost;
            result_next.entry_port = dst_port;
          end
        end else if (rq.dest_id == own_id) begin
          result_next.status      = ST_SELF;
          result_next.entry_valid = 1'b0;
        end else if (full) begin
          result_next.status      = ST_FULL;
          result_next.entry_valid = 1'b0;
        end else begin
          ram_we    = 1'b1;
          count_inc = 1'b1;
        end
      end
      REQ_READ: begin
        if (rd_ok) begin
          result_next = '{status: ST_READ_OK, entry_dest: ram_rdata.dest,
                          entry_cost: ram_rdata.cost, entry_port: ram_rdata.port,
                          entry_valid: 1'b1};
        end
      end
      default: begin
      end
    endcase
    if (!dp_cmd.decide) begin
      ram_we    = 1'b0;
      count_inc = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= dp_cmd.decide;
      if (count_inc) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.decide) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("route count beyond table size");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.decide |-> !cmp_vld && !dp_cmd.scan_rd)
    else $error("decision taken before the scan drained");
`endif

endmodule

@@ sv/distance_vector_route_update_unit.sv @@
// Top level of the distance-vector route update unit with its APB register.
// Load and advertisement: after accept, the table is scanned, one entry read per
// cycle over the routes held (skipped on an empty table), then drained and decided;
// a read issues one indexed table read, then decides; an unused request code decides at once.
// The next item is taken in the cycle the result is strobed.
// Reset (rst, synchronous): empties the table, sets own_id to 65, no clear pass.
module distance_vector_route_update_unit import dvru_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  request_t           request,
  output logic               done,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic [7:0] own_id;
  logic       cfg_write;
  logic       accept;

  // Configuration: one register, own_id, at byte address 0
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= OWN_ID_RESET;
    end else if (cfg_write && paddr[PADDR_W-1] == REG_OWN_ID) begin
      own_id <= pwdata[7:0];
    end
  end

  // Decode the read address; anything past the map reads zero
  always_comb begin
    prdata = 32'd0;
    unique case (paddr[PADDR_W-1])
      REG_OWN_ID: prdata = {24'd0, own_id};
      default:    prdata = 32'd0;
    endcase
  end

  assign accept = start & ~busy;

  // Sequence the scan and the decision
  dvru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (request.req_type),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .busy      (busy)
  );

  // Hold the table, compare, relax and register the result item
  dvru_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .own_id    (own_id),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .done      (done),
    .result    (result)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("item accepted but unit not busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobed without work in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobed on two cycles in a row");

  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.capture |-> accept)
    else $error("request captured outside an accept");
`endif

endmodule
